FILE: src/smse_pkg.sv
// Shared constants and types for the stable merge sort engine.
package smse_pkg;

   // Capacity of one set and the widths that follow from it.
   localparam int MAX_ITEMS = 64;
   localparam int DATA_W    = 32;
   localparam int ADDR_W    = $clog2(MAX_ITEMS);
   localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic [ADDR_W-1:0]        addr_type;
   typedef logic [CNT_W-1:0]         cnt_type;

   // Memory requests from the merge sequencer.
   typedef struct packed {
      logic     wr_en;
      addr_type wr_addr;
      data_type wr_data;
      addr_type rd_addr_p;
      addr_type rd_addr_q;
      logic     src_bank;
   } merge_req_type;

   // Completion report from the merge sequencer.
   typedef struct packed {
      logic done;
      logic result_bank;
   } merge_status_type;

endpackage

FILE: src/smse_ram.sv
// Generic memory with one write port and two registered read ports.
module smse_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read ports.
   always_ff @(posedge clock) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

FILE: src/smse_merge.sv
// Bottom-up merge sequencer that ping-pongs between the two memory banks.
module smse_merge
   import smse_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  cnt_type          count,
   input  data_type         rd_data_p,
   input  data_type         rd_data_q,
   output merge_req_type    req,
   output merge_status_type status
);

   typedef enum logic [1:0] {IDLE, SETUP, PRIME, MERGE} state_type;
   typedef logic [CNT_W:0] sum_type;

   state_type state_ff;
   cnt_type   n_ff;
   cnt_type   width_ff;
   cnt_type   lo_ff;
   cnt_type   mid_ff;
   cnt_type   hi_ff;
   cnt_type   p_ff;
   cnt_type   q_ff;
   cnt_type   k_ff;
   logic      src_ff;
   logic      done_ff;

   sum_type   lo_plus_w;
   sum_type   lo_plus_2w;
   sum_type   width_x2;
   cnt_type   mid_calc;
   cnt_type   hi_calc;
   logic      take_p;
   cnt_type   p_next;
   cnt_type   q_next;
   cnt_type   k_next;
   cnt_type   rd_p_idx;
   cnt_type   rd_q_idx;

   // Bounds of the next pair of runs, clipped to the set size.
   always_comb begin
      lo_plus_w  = {1'b0, lo_ff} + {1'b0, width_ff};
      lo_plus_2w = lo_plus_w + {1'b0, width_ff};
      width_x2   = {width_ff, 1'b0};
      mid_calc   = (lo_plus_w > {1'b0, n_ff}) ? n_ff : lo_plus_w[CNT_W-1:0];
      hi_calc    = (lo_plus_2w > {1'b0, n_ff}) ? n_ff : lo_plus_2w[CNT_W-1:0];
   end

   // Merge decision: the left run wins ties, which keeps the sort stable.
   always_comb begin
      take_p = (q_ff >= hi_ff) || ((p_ff < mid_ff) && (rd_data_p <= rd_data_q));
      p_next = take_p ? p_ff + cnt_type'(1) : p_ff;
      q_next = take_p ? q_ff : q_ff + cnt_type'(1);
      k_next = k_ff + cnt_type'(1);
   end

   // The read addresses follow the next heads so one element merges per cycle.
   always_comb begin
      rd_p_idx = (state_ff == MERGE) ? p_next : p_ff;
      rd_q_idx = (state_ff == MERGE) ? q_next : q_ff;
      req.wr_en     = (state_ff == MERGE);
      req.wr_addr   = k_ff[ADDR_W-1:0];
      req.wr_data   = take_p ? rd_data_p : rd_data_q;
      req.rd_addr_p = rd_p_idx[ADDR_W-1:0];
      req.rd_addr_q = rd_q_idx[ADDR_W-1:0];
      req.src_bank  = src_ff;
      status.done        = done_ff;
      status.result_bank = src_ff;
   end

   // Pass and run sequencing.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         done_ff  <= 1'b0;
         src_ff   <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            IDLE: begin
               if (start) begin
                  n_ff     <= count;
                  width_ff <= cnt_type'(1);
                  lo_ff    <= '0;
                  src_ff   <= 1'b0;
                  if (count <= cnt_type'(1)) begin
                     done_ff <= 1'b1;
                  end else begin
                     state_ff <= SETUP;
                  end
               end
            end
            SETUP: begin
               mid_ff   <= mid_calc;
               hi_ff    <= hi_calc;
               p_ff     <= lo_ff;
               q_ff     <= mid_calc;
               k_ff     <= lo_ff;
               state_ff <= PRIME;
            end
            PRIME: begin
               state_ff <= MERGE;
            end
            MERGE: begin
               p_ff <= p_next;
               q_ff <= q_next;
               k_ff <= k_next;
               if (k_next == hi_ff) begin
                  if (hi_ff == n_ff) begin
                     // End of a pass: swap banks and double the run width.
                     src_ff   <= ~src_ff;
                     lo_ff    <= '0;
                     width_ff <= width_x2[CNT_W-1:0];
                     if (width_x2 >= {1'b0, n_ff}) begin
                        done_ff  <= 1'b1;
                        state_ff <= IDLE;
                     end else begin
                        state_ff <= SETUP;
                     end
                  end else begin
                     lo_ff    <= hi_ff;
                     state_ff <= SETUP;
                  end
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

endmodule

FILE: src/stable_merge_sort_engine_unit.sv
// Top level of the stable merge sort engine: loading, sorting and emission.
//
// Items are loaded one per cycle until an item with req_last set; up to 64 are
// kept and any beyond that are dropped, which sets rsp_overflow on every result
// of the set. The set is then sorted in ascending signed order, equal values
// keeping their arrival order, by bottom-up merge passes between two 64-entry
// memory banks. Each pair of runs passes through the SETUP and PRIME states and
// then merges one element per cycle, and there are ceil(log2(n)) passes for a
// set of n items. The one write port of the destination bank sets the merge
// rate. Results leave one per cycle through an output register while rsp_stall
// is low; no input item is taken while a set is sorted or emitted.
module stable_merge_sort_engine_unit
   import smse_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  data_type req_value,
   input  logic     req_last,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output data_type rsp_value,
   output logic     rsp_last,
   output logic     rsp_overflow
);

   typedef enum logic [1:0] {LOAD, SORT, EMIT_PRIME, EMIT} state_type;

   state_type        state_ff;
   cnt_type          count_ff;
   logic             drop_ff;
   cnt_type          n_ff;
   logic             ovf_ff;
   cnt_type          emit_ff;
   logic             start_ff;
   logic             rsp_valid_ff;
   data_type         rsp_value_ff;
   logic             rsp_last_ff;
   logic             rsp_overflow_ff;

   logic             accept;
   logic             room;
   logic             load_we;
   logic             emitting;
   logic             out_free;
   logic             emit_take;
   cnt_type          emit_next;
   cnt_type          emit_rd_idx;
   addr_type         port_p_addr;
   data_type         a_data_p;
   data_type         a_data_q;
   data_type         b_data_p;
   data_type         b_data_q;
   data_type         merge_data_p;
   data_type         merge_data_q;
   data_type         emit_data;
   logic             a_we;
   addr_type         a_waddr;
   data_type         a_wdata;
   logic             b_we;
   merge_req_type    mreq;
   merge_status_type mstat;

   // Input handshake and load control.
   always_comb begin
      req_stall = (state_ff != LOAD);
      accept    = req_valid && !req_stall;
      room      = (count_ff < cnt_type'(MAX_ITEMS));
      load_we   = accept && room;
   end

   // Emission control: the read address runs one step ahead when an item leaves.
   always_comb begin
      emitting    = (state_ff == EMIT_PRIME) || (state_ff == EMIT);
      out_free    = !rsp_valid_ff || !rsp_stall;
      emit_take   = (state_ff == EMIT) && out_free;
      emit_next   = emit_ff + cnt_type'(1);
      emit_rd_idx = emit_take ? emit_next : emit_ff;
      port_p_addr = emitting ? emit_rd_idx[ADDR_W-1:0] : mreq.rd_addr_p;
   end

   // Bank steering: bank A takes loads, and merge writes go to the other bank.
   always_comb begin
      a_we         = load_we || (mreq.wr_en && mreq.src_bank);
      a_waddr      = load_we ? count_ff[ADDR_W-1:0] : mreq.wr_addr;
      a_wdata      = load_we ? req_value : mreq.wr_data;
      b_we         = mreq.wr_en && !mreq.src_bank;
      merge_data_p = mreq.src_bank ? b_data_p : a_data_p;
      merge_data_q = mreq.src_bank ? b_data_q : a_data_q;
      emit_data    = mstat.result_bank ? b_data_p : a_data_p;
   end

   smse_ram #(
      .DEPTH(MAX_ITEMS),
      .WIDTH(DATA_W)
   ) u_bank_a (
      .clock    (clock),
      .wr_en    (a_we),
      .wr_addr  (a_waddr),
      .wr_data  (a_wdata),
      .rd_addr_a(port_p_addr),
      .rd_addr_b(mreq.rd_addr_q),
      .rd_data_a(a_data_p),
      .rd_data_b(a_data_q)
   );

   smse_ram #(
      .DEPTH(MAX_ITEMS),
      .WIDTH(DATA_W)
   ) u_bank_b (
      .clock    (clock),
      .wr_en    (b_we),
      .wr_addr  (mreq.wr_addr),
      .wr_data  (mreq.wr_data),
      .rd_addr_a(port_p_addr),
      .rd_addr_b(mreq.rd_addr_q),
      .rd_data_a(b_data_p),
      .rd_data_b(b_data_q)
   );

   smse_merge u_merge (
      .clock    (clock),
      .reset    (reset),
      .start    (start_ff),
      .count    (n_ff),
      .rd_data_p(merge_data_p),
      .rd_data_q(merge_data_q),
      .req      (mreq),
      .status   (mstat)
   );

   // Main sequence and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= LOAD;
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_ff <= 1'b0;
         if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            LOAD: begin
               if (accept) begin
                  if (req_last) begin
                     n_ff     <= room ? count_ff + cnt_type'(1) : count_ff;
                     ovf_ff   <= drop_ff || !room;
                     count_ff <= '0;
                     drop_ff  <= 1'b0;
                     start_ff <= 1'b1;
                     state_ff <= SORT;
                  end else if (room) begin
                     count_ff <= count_ff + cnt_type'(1);
                  end else begin
                     drop_ff <= 1'b1;
                  end
               end
            end
            SORT: begin
               if (mstat.done) begin
                  emit_ff  <= '0;
                  state_ff <= EMIT_PRIME;
               end
            end
            EMIT_PRIME: begin
               state_ff <= EMIT;
            end
            EMIT: begin
               if (out_free) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_value_ff    <= emit_data;
                  rsp_last_ff     <= (emit_next == n_ff);
                  rsp_overflow_ff <= ovf_ff;
                  emit_ff         <= emit_next;
                  if (emit_next == n_ff) begin
                     state_ff <= LOAD;
                  end
               end
            end
            default: begin
               state_ff <= LOAD;
            end
         endcase
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_value    = rsp_value_ff;
   assign rsp_last     = rsp_last_ff;
   assign rsp_overflow = rsp_overflow_ff;

endmodule

FILE: test/tb.sv
// Testbench for the stable merge sort engine: random sets in, sorted items checked out.
module tb;
   import smse_pkg::*;

   // One item waiting to be offered, with its pacing flags.
   typedef struct {
      data_type value;
      logic     is_last;
      bit       wait_empty;
      bit       hold_after;
   } load_entry_type;

   // One expected sorted item.
   typedef struct {
      data_type value;
      logic     is_last;
      logic     overflow;
   } sorted_entry_type;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_stall;
   data_type req_value = '0;
   logic     req_last = 1'b0;
   logic     rsp_valid;
   logic     rsp_stall = 1'b0;
   data_type rsp_value;
   logic     rsp_last;
   logic     rsp_overflow;

   load_entry_type   load_q[$];
   sorted_entry_type sorted_q[$];

   // Predicted contents of the set being loaded.
   data_type set_store[MAX_ITEMS];
   int       set_count = 0;
   bit       set_dropped = 1'b0;

   int total_items = 0;
   int accepted_count = 0;
   int error_count = 0;

   // Sender pacing.
   int burst_left = 0;
   int gap_left = 0;
   logic hold_armed = 1'b0;

   // Receiver pacing.
   int stall_mode = 0;
   int stall_left = 0;
   int stall_phase = 0;
   int holdoff_left = 0;
   bit holdoff_done = 1'b0;

   stable_merge_sort_engine_unit DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_value    (req_value),
      .req_last     (req_last),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_value    (rsp_value),
      .rsp_last     (rsp_last),
      .rsp_overflow (rsp_overflow)
   );

   always #1 clock = ~clock;

   // Report one mismatch on a line of its own and count it.
   task automatic report_mismatch(string msg);
      error_count++;
      $display("mismatch at %0t: %s", $time, msg);
   endtask

   // Store one element of the set; on the final element sort stably and queue the results.
   function automatic void load_element(data_type value, logic is_last);
      data_type         key;
      int               j;
      sorted_entry_type res;
      if (set_count < MAX_ITEMS) begin
         set_store[set_count] = value;
         set_count++;
      end else begin
         set_dropped = 1'b1;
      end
      if (is_last) begin
         // Insertion sort that never moves an element past an equal one.
         for (int i = 1; i < set_count; i++) begin
            key = set_store[i];
            j = i;
            while (j > 0 && set_store[j-1] > key) begin
               set_store[j] = set_store[j-1];
               j--;
            end
            set_store[j] = key;
         end
         for (int i = 0; i < set_count; i++) begin
            res.value = set_store[i];
            res.is_last = (i == set_count - 1);
            res.overflow = set_dropped;
            sorted_q.push_back(res);
         end
         set_count = 0;
         set_dropped = 1'b0;
      end
   endfunction

   // Random element: extremes, a narrow band that gives many equal values, or any word.
   function automatic data_type pick_value();
      case ($urandom_range(0, 7))
         0: begin
            case ($urandom_range(0, 3))
               0: return 32'sh7FFFFFFF;
               1: return 32'sh80000000;
               2: return '0;
               default: return -1;
            endcase
         end
         1, 2: return data_type'($urandom_range(0, 8)) - 4;
         default: return data_type'($urandom);
      endcase
   endfunction

   function automatic void add_item(data_type value, logic is_last, bit wait_empty,
                                    bit hold_after);
      load_entry_type e;
      e.value = value;
      e.is_last = is_last;
      e.wait_empty = wait_empty;
      e.hold_after = hold_after;
      load_q.push_back(e);
      total_items++;
   endfunction

   // A set of random elements; the pause flag sits on its first item and the hold flag on its last.
   function automatic void add_random_set(int size, bit wait_empty, bit hold_after);
      for (int i = 0; i < size; i++)
         add_item(pick_value(), i == size - 1, wait_empty && i == 0,
                  hold_after && i == size - 1);
   endfunction

   // Driver: offers queued items in bursts; the prediction runs at each accepted item.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_value <= '0;
         req_last <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            accepted_count++;
            load_element(req_value, req_last);
         end
         if (!(req_valid && req_stall)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (load_q.size() != 0 &&
                         !(load_q[0].wait_empty && sorted_q.size() != 0)) begin
               req_value <= load_q[0].value;
               req_last <= load_q[0].is_last;
               req_valid <= 1'b1;
               if (load_q[0].hold_after)
                  hold_armed <= 1'b1;
               void'(load_q.pop_front());
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 24);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver stall: one long hold-off once armed, otherwise a changing pattern.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_armed && rsp_valid && !holdoff_done) begin
            holdoff_left = 600;
            holdoff_done = 1'b1;
         end
         if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 150);
         end else begin
            stall_left--;
         end
         stall_phase++;
         if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (stall_mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= (stall_phase % 3 == 0);
            endcase
         end
      end
   end

   // Monitor: every accepted sorted item is compared with the oldest expectation.
   always @(posedge clock) begin : monitor
      sorted_entry_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (sorted_q.size() == 0) begin
            report_mismatch($sformatf("unexpected item value %0d", rsp_value));
         end else begin
            want = sorted_q.pop_front();
            if (rsp_value !== want.value)
               report_mismatch($sformatf("value %0d, expected %0d", rsp_value, want.value));
            if (rsp_last !== want.is_last)
               report_mismatch($sformatf("last %b, expected %b", rsp_last, want.is_last));
            if (rsp_overflow !== want.overflow)
               report_mismatch($sformatf("overflow %b, expected %b",
                                         rsp_overflow, want.overflow));
         end
      end
   end

   // Stimulus, reset and the final verdict.
   initial begin
      // Directed sets: a single element, extremes with repeats, all equal,
      // descending and ascending order.
      add_item(32'sh80000000, 1'b1, 1'b0, 1'b0);
      add_item(32'sh7FFFFFFF, 1'b0, 1'b0, 1'b0);
      add_item(32'sh80000000, 1'b0, 1'b0, 1'b0);
      add_item(0, 1'b0, 1'b0, 1'b0);
      add_item(-1, 1'b0, 1'b0, 1'b0);
      add_item(1, 1'b0, 1'b0, 1'b0);
      add_item(32'sh80000000, 1'b0, 1'b0, 1'b0);
      add_item(32'sh7FFFFFFF, 1'b0, 1'b0, 1'b0);
      add_item(0, 1'b1, 1'b0, 1'b0);
      for (int i = 0; i < 4; i++)
         add_item(5, i == 3, 1'b0, 1'b0);
      for (int i = 0; i < 6; i++)
         add_item(100 - 60 * i, i == 5, 1'b0, 1'b0);
      for (int i = 0; i < 6; i++)
         add_item(i - 3, i == 5, 1'b0, 1'b0);

      // Random sets: a few small ones, a full set with a long receiver hold-off
      // followed at once by a set whose last element is dropped, then more.
      add_random_set($urandom_range(1, 12), 1'b1, 1'b0);
      for (int i = 0; i < 4; i++)
         add_random_set($urandom_range(1, 16), 1'b0, 1'b0);
      add_random_set(MAX_ITEMS, 1'b1, 1'b1);
      add_random_set(MAX_ITEMS + 1, 1'b0, 1'b0);
      while (total_items < 330)
         add_random_set($urandom_range(1, 16), $urandom_range(0, 3) == 0, 1'b0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (accepted_count < total_items)
         @(posedge clock);
      while (sorted_q.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Run limit.
   initial begin
      #400000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
